FILE: sv/kvt_pkg.sv
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int KVT_TABLE_DEPTH = 16;
    localparam int KVT_KEY_W       = 31;
    localparam int KVT_VAL_W       = 32;
    localparam int KVT_OP_W        = 2;
    localparam int KVT_STATUS_W    = 3;

    typedef logic [KVT_KEY_W-1:0]        t_key;
    typedef logic signed [KVT_VAL_W-1:0] t_value;
    // key memory word: valid mark on top of the key
    typedef logic [KVT_KEY_W:0]          t_key_word;

    typedef enum logic [KVT_OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } t_opcode;

    typedef enum logic [KVT_STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic key_we;
        logic val_we;
    } t_wr_ctl;

endpackage

FILE: sv/kvt_if.sv
`timescale 1ns / 1ps

interface kvt_req_if;
    logic                                valid;
    logic                                ready;
    logic [kvt_pkg::KVT_OP_W-1:0]        opcode;
    logic [kvt_pkg::KVT_KEY_W-1:0]       key;
    logic signed [kvt_pkg::KVT_VAL_W-1:0] value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface kvt_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [kvt_pkg::KVT_STATUS_W-1:0]     status;
    logic signed [kvt_pkg::KVT_VAL_W-1:0] value_out;

    modport source (output valid, output status, output value_out, input ready);
    modport sink   (input valid, input status, input value_out, output ready);
endinterface

FILE: sv/key_value_table_unit.sv
`timescale 1ns / 1ps

// Associative table of up to TABLE_DEPTH unique keys, each with a signed value. Every
// request (insert or update, remove, lookup) gives exactly one response. Keys with a
// valid mark live in one single-port-read memory and values in another; a request is
// served by one sweep over all entries, one memory read per cycle, with each read value
// compared once it is registered, then a drain step (S_DRAIN) for the last compare and
// a write-back/response step (S_EXEC) that waits while the output register still holds
// an unaccepted response. One request is in work at a time; a finished response waits
// in the output register while the next request is accepted. After reset a clearing
// pass over every entry marks it free; no request is accepted during it.
module key_value_table_unit #(
    parameter int TABLE_DEPTH = kvt_pkg::KVT_TABLE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvt_req_if.sink    i_req,
    kvt_rsp_if.source  o_rsp
);
    import kvt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    t_state r_state, n_state;

    logic [AW-1:0]         r_addr;
    logic                  r_cmp_vld;
    logic [AW-1:0]         r_cmp_addr;
    logic [KVT_OP_W-1:0]   r_op;
    t_key                  r_key;
    t_value                r_value;
    logic                  r_hit;
    logic [AW-1:0]         r_hit_idx;
    t_value                r_hit_val;
    logic                  r_free_ok;
    logic [AW-1:0]         r_free_idx;
    logic                  r_out_vld;
    t_status               r_out_status;
    t_value                r_out_value;

    t_key_word             rd_key_word;
    t_value                rd_value;
    t_wr_ctl               wr_ctl;
    logic [AW-1:0]         wr_addr;
    t_key_word             wr_key_word;
    t_value                wr_value;
    t_status               res_status;
    t_value                res_value;

    logic                  req_acc;
    logic                  slot_free;
    logic                  rd_valid;
    logic                  rd_match;

    assign slot_free = !r_out_vld || o_rsp.ready;
    assign req_acc   = i_req.valid && i_req.ready;
    assign rd_valid  = rd_key_word[KVT_KEY_W];
    assign rd_match  = rd_valid && (rd_key_word[KVT_KEY_W-1:0] == r_key);

    kvt_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk         (i_clk),
        .i_rd_addr     (r_addr),
        .i_wr_ctl      (wr_ctl),
        .i_wr_addr     (wr_addr),
        .i_wr_key_word (wr_key_word),
        .i_wr_value    (wr_value),
        .o_rd_key_word (rd_key_word),
        .o_rd_value    (rd_value)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST_IDX) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_addr == LAST_IDX) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        i_req.ready  = 1'b0;
        wr_ctl       = '0;
        wr_addr      = r_addr;
        wr_key_word  = '0;
        wr_value     = r_value;
        res_status   = ST_NOT_FOUND;
        res_value    = '0;

        // decision made from the sweep results, used in the write-back cycle
        case (r_op)
            OP_INSERT: begin
                if (r_hit) begin
                    wr_ctl.val_we = 1'b1;
                    wr_addr       = r_hit_idx;
                    res_status    = ST_UPDATED;
                end else if (r_free_ok) begin
                    wr_ctl.key_we = 1'b1;
                    wr_ctl.val_we = 1'b1;
                    wr_addr       = r_free_idx;
                    wr_key_word   = {1'b1, r_key};
                    res_status    = ST_INSERTED;
                end else begin
                    res_status    = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (r_hit) begin
                    wr_ctl.key_we = 1'b1;
                    wr_addr       = r_hit_idx;
                    wr_key_word   = {1'b0, r_key};
                    res_status    = ST_REMOVED;
                end
            end
            OP_LOOKUP: begin
                if (r_hit) begin
                    res_status = ST_FOUND;
                    res_value  = r_hit_val;
                end
            end
            default: res_status = ST_NOT_FOUND;
        endcase

        unique case (r_state)
            S_CLEAR: begin
                wr_ctl      = '{key_we: 1'b1, val_we: 1'b0};
                wr_addr     = r_addr;
                wr_key_word = '0;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                wr_ctl      = '0;
            end
            S_EXEC: begin
                if (!slot_free) wr_ctl = '0;
            end
            default: wr_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == S_SCAN);
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
            end else if (req_acc) begin
                r_addr <= '0;
            end
            if (r_state == S_EXEC && slot_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_addr <= r_addr;
        if (req_acc) begin
            r_op      <= i_req.opcode;
            r_key     <= i_req.key;
            r_value   <= i_req.value;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_cmp_vld) begin
            if (rd_match) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_addr;
                r_hit_val <= rd_value;
            end
            // keep the lowest free entry
            if (!rd_valid && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_cmp_addr;
            end
        end
        if (r_state == S_EXEC && slot_free) begin
            r_out_status <= res_status;
            r_out_value  <= res_value;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.value_out = r_out_value;

endmodule

FILE: sv/kvt_store.sv
`timescale 1ns / 1ps

module kvt_store #(
    parameter int DEPTH = kvt_pkg::KVT_TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic [AW-1:0]      i_rd_addr,
    input  kvt_pkg::t_wr_ctl   i_wr_ctl,
    input  logic [AW-1:0]      i_wr_addr,
    input  kvt_pkg::t_key_word i_wr_key_word,
    input  kvt_pkg::t_value    i_wr_value,
    output kvt_pkg::t_key_word o_rd_key_word,
    output kvt_pkg::t_value    o_rd_value
);
    import kvt_pkg::*;

    t_key_word key_mem [DEPTH];
    t_value    val_mem [DEPTH];

    t_key_word r_rd_key_word;
    t_value    r_rd_value;

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.key_we) begin
            key_mem[i_wr_addr] <= i_wr_key_word;
        end
        r_rd_key_word <= key_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.val_we) begin
            val_mem[i_wr_addr] <= i_wr_value;
        end
        r_rd_value <= val_mem[i_rd_addr];
    end

    assign o_rd_key_word = r_rd_key_word;
    assign o_rd_value    = r_rd_value;

endmodule

FILE: sv/kvt_checker.sv
`timescale 1ns / 1ps

module kvt_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_req_valid,
    input logic                                 i_req_ready,
    input logic                                 i_rsp_valid,
    input logic                                 i_rsp_ready,
    input logic [kvt_pkg::KVT_STATUS_W-1:0]     i_rsp_status,
    input logic signed [kvt_pkg::KVT_VAL_W-1:0] i_rsp_value_out
);
    import kvt_pkg::*;

    // clearing pass follows reset, so no request is taken right after it
    a_no_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("request ready right after reset");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while another is in work");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_value_out)))
        else $error("stalled response changed");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status <= ST_FULL))
        else $error("response status out of range");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_FOUND) |-> (i_rsp_value_out == '0))
        else $error("value nonzero on a response that is not found");

endmodule

bind key_value_table_unit kvt_checker u_kvt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_value_out (o_rsp.value_out)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import kvt_pkg::*;

    localparam logic [KVT_OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int KEY_POOL       = 20;
    localparam int RANDOM_REQS    = 1925;
    localparam int PHASE_LEN      = 128;
    localparam int QUIET_START    = 6000;
    localparam int QUIET_END      = 11000;
    localparam int HOLDOFF_AT     = 20000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 600000;

    typedef struct {
        logic [KVT_OP_W-1:0] opcode;
        t_key                key;
        t_value              value;
    } t_req_item;

    typedef struct {
        t_status status;
        t_value  value_out;
    } t_rsp_item;

    logic i_clk;
    logic i_rst_n;

    kvt_req_if req_if();
    kvt_rsp_if rsp_if();

    key_value_table_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_req_item pending_reqs[$];
    t_rsp_item expected_rsps[$];

    // shadow copy of the table contents
    bit     tbl_valid[KVT_TABLE_DEPTH];
    t_key   tbl_key[KVT_TABLE_DEPTH];
    t_value tbl_val[KVT_TABLE_DEPTH];

    int cyc;
    int mismatches;
    int n_accepted;
    int status_hits[6];
    t_key key_pool[KEY_POOL];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d requests left, %0d responses outstanding",
                     cyc, pending_reqs.size(), expected_rsps.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic bit quiet_window();
        return cyc >= QUIET_START && cyc < QUIET_END;
    endfunction

    // applies one request to the shadow table and returns the response it gives
    function automatic t_rsp_item predict_table_op(t_req_item r);
        t_rsp_item res;
        int hit;
        int slot;
        res.status    = ST_NOT_FOUND;
        res.value_out = '0;
        hit  = -1;
        slot = -1;
        for (int i = 0; i < KVT_TABLE_DEPTH; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == r.key) hit = i;
            if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        case (r.opcode)
            OP_INSERT: begin
                if (hit >= 0) begin
                    tbl_val[hit] = r.value;
                    res.status   = ST_UPDATED;
                end else if (slot >= 0) begin
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot]   = r.key;
                    tbl_val[slot]   = r.value;
                    res.status      = ST_INSERTED;
                end else begin
                    res.status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    res.status     = ST_REMOVED;
                end
            end
            OP_LOOKUP: begin
                if (hit >= 0) begin
                    res.value_out = tbl_val[hit];
                    res.status    = ST_FOUND;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic add_req(logic [KVT_OP_W-1:0] op, t_key key, t_value value);
        t_req_item r;
        r.opcode = op;
        r.key    = key;
        r.value  = value;
        pending_reqs.push_back(r);
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
    endtask

    // request driver
    always @(posedge i_clk) begin : req_driver
        bit fire;
        fire = req_if.valid === 1'b1 && req_if.ready === 1'b1;
        if (fire) begin
            expected_rsps.push_back(predict_table_op(pending_reqs.pop_front()));
            n_accepted++;
        end
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid === 1'b1 && !fire) begin
            // hold the current transaction until it is taken
        end else if (pending_reqs.size() > 0 &&
                     !(!quiet_window() && $urandom_range(99) < 17)) begin
            req_if.valid  <= 1'b1;
            req_if.opcode <= pending_reqs[0].opcode;
            req_if.key    <= pending_reqs[0].key;
            req_if.value  <= pending_reqs[0].value;
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // response sink, with one long hold-off so the request side backs up
    always @(posedge i_clk) begin : rsp_sink
        int sink_cycles;
        int holdoff_left;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            sink_cycles++;
            if (sink_cycles == HOLDOFF_AT) holdoff_left = HOLDOFF_CYCLES;
            if (holdoff_left > 0) begin
                holdoff_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= quiet_window() || $urandom_range(99) >= 17;
            end
        end
    end

    always @(posedge i_clk) begin : rsp_monitor
        t_rsp_item want;
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch($sformatf("response with none outstanding: status %0d value %0d",
                                          rsp_if.status, rsp_if.value_out));
            end else begin
                want = expected_rsps.pop_front();
                status_hits[want.status]++;
                if (rsp_if.status !== want.status || rsp_if.value_out !== want.value_out)
                    report_mismatch($sformatf(
                        "response differs: status %0d value %0d, wanted status %0d value %0d",
                        rsp_if.status, rsp_if.value_out, want.status, want.value_out));
            end
        end
    end

    initial begin : main_seq
        bit                  fill_phase;
        int                  roll;
        logic [KVT_OP_W-1:0] op;
        t_key                key;
        t_value              value;

        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.opcode = '0;
        req_if.key    = '0;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = t_key'($urandom);

        // directed: misses on an empty table, the unused opcode, extreme keys and values
        add_req(OP_LOOKUP, 31'd5, 32'sd9);
        add_req(OP_REMOVE, 31'd5, '0);
        add_req(OP_UNUSED, '0, '1);
        add_req(OP_INSERT, '0, -32'sd1);
        add_req(OP_INSERT, '1, 32'sh8000_0000);
        add_req(OP_INSERT, '0, 32'sh7fff_ffff);
        add_req(OP_LOOKUP, '0, '0);
        // fill the table, then overflow it and update while full
        for (int i = 1; i <= KVT_TABLE_DEPTH - 2; i++)
            add_req(OP_INSERT, t_key'(32'h0123_4567 * i), t_value'($urandom));
        add_req(OP_INSERT, 31'h2aaa_aaaa, 32'sd77);
        add_req(OP_INSERT, '0, -32'sd1);
        add_req(OP_LOOKUP, '0, 32'sd3);
        add_req(OP_REMOVE, '0, '0);

        // random: alternate fill-heavy and drain-heavy phases over a small key pool
        fill_phase = 1'b0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % PHASE_LEN == 0) fill_phase = !fill_phase;
            roll = $urandom_range(99);
            if (fill_phase)
                op = roll < 55 ? OP_INSERT : roll < 65 ? OP_REMOVE :
                     roll < 95 ? OP_LOOKUP : OP_UNUSED;
            else
                op = roll < 15 ? OP_INSERT : roll < 60 ? OP_REMOVE :
                     roll < 95 ? OP_LOOKUP : OP_UNUSED;
            if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
            else key = t_key'($urandom);
            case ($urandom_range(19))
                0:       value = -32'sd1;
                1:       value = 32'sh8000_0000;
                2:       value = 32'sh7fff_ffff;
                3:       value = '0;
                default: value = t_value'($urandom);
            endcase
            add_req(op, key, value);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge i_clk);
        // let any stray response show up
        repeat (2 * KVT_TABLE_DEPTH + 8) @(posedge i_clk);

        $display("%0d requests over alternating fill and drain phases, one long output stall",
                 n_accepted);
        $display("responses: inserted %0d, updated %0d, removed %0d, found %0d, not found %0d, full %0d",
                 status_hits[ST_INSERTED], status_hits[ST_UPDATED], status_hits[ST_REMOVED],
                 status_hits[ST_FOUND], status_hits[ST_NOT_FOUND], status_hits[ST_FULL]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: key_value_table_unit.f
sv/kvt_pkg.sv
sv/kvt_if.sv
sv/kvt_store.sv
sv/key_value_table_unit.sv
sv/kvt_checker.sv
dv/testbench.sv
